// File: hdl/lbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbf_pkg: shared types and constants of the learning bridge forwarder
// Request and result formats, the forwarding action codes, the queue element
// and the state encoding of the table engine.
// ----------------------------------------------------------------------------
package lbf_pkg;

  localparam int unsigned AddrWidth         = 48;
  localparam int unsigned DefaultTableDepth = 64;
  localparam int unsigned QueueDepth        = 2;

  typedef enum logic [1:0] {
    ActFilter  = 2'd0,
    ActForward = 2'd1,
    ActFlood   = 2'd2
  } action_e;

  // One frame header as it enters the bridge.
  typedef struct packed {
    logic                 ingress_port;
    logic [AddrWidth-1:0] dst_addr;
    logic [AddrWidth-1:0] src_addr;
  } req_t;

  // The forwarding decision for one frame.
  typedef struct packed {
    action_e action;
    logic    out_port;
    logic    learned;
    logic    learn_dropped;
  } res_t;

  // Queue element: the header plus the class the front end gives it.
  typedef struct packed {
    req_t hdr;
    logic same_addr;
  } job_t;

  // Status of the table engine, watched at the top level.
  typedef struct packed {
    logic table_full;
    logic learn_wr;
  } back_stat_t;

  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StScan   = 2'd1,
    StDrain  = 2'd2,
    StFinish = 2'd3
  } back_state_e;

endpackage
`default_nettype wire

// File: hdl/learning_bridge_forwarder.sv
`default_nettype none
// Each request is taken from the queue, its table scan runs over the learned entries
// (none while the table is empty) and the result waits out any output stall.
// The engine takes no new request until the last result is loaded, and the scan
// reads one entry per cycle through the single read port.
// Reset empties the queue and sets the fill count to zero; the table memory is
// not cleared, since only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
// learning_bridge_forwarder: two-port transparent learning bridge
// Looks up each frame's destination in the address table to filter, forward
// or flood it, and learns the frame's source address with its ingress port.
// ----------------------------------------------------------------------------
module learning_bridge_forwarder #(
  parameter int unsigned TABLE_DEPTH = lbf_pkg::DefaultTableDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire lbf_pkg::req_t req_i,
  output logic               res_valid_o,
  input  wire logic          res_stall_i,
  output lbf_pkg::res_t      res_o
);

  // The front end takes each request and queues it with a flag that tells
  // whether its source and destination addresses are the same.
  logic                job_valid;
  logic                job_pop;
  lbf_pkg::job_t       job;
  lbf_pkg::back_stat_t back_stat;

  lbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  // The back end scans the table for both addresses at once, so the lookup
  // sees the table as it stood before this frame; the source is learned only
  // when the result is loaded into the output register.
  lbf_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (res_o),
    .stat_o      (back_stat)
  );

  // A request is taken from the queue only when one is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_pop |-> job_valid)
    else $error("queue popped while empty");

  // Once the table is full it stays full, because entries are never removed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.table_full |=> back_stat.table_full)
    else $error("table left the full condition");

  // No entry is written into a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.learn_wr |-> !back_stat.table_full)
    else $error("learn write into full table");

  // A result never claims both a learned and a dropped source.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.learned && res_o.learn_dropped))
    else $error("learned and learn_dropped both set");

  // The output port is nonzero only on a forward decision.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.out_port) |-> (res_o.action == lbf_pkg::ActForward))
    else $error("out_port set without forward action");

endmodule
`default_nettype wire

// File: hdl/lbf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbf_front: request intake and queue
// Accepts frame headers, marks those whose source equals their destination,
// and holds them in a short queue for the table engine.
// ----------------------------------------------------------------------------
module lbf_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire lbf_pkg::req_t req_i,
  output logic               job_valid_o,
  output lbf_pkg::job_t      job_o,
  input  wire logic          job_pop_i
);

  localparam int unsigned PtrW = $clog2(lbf_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(lbf_pkg::QueueDepth + 1);

  lbf_pkg::job_t queue_q [lbf_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            push;
  lbf_pkg::job_t   job_new;

  assign req_stall_o = (fill_q == CntW'(lbf_pkg::QueueDepth));
  assign job_valid_o = (fill_q != '0);
  assign job_o       = queue_q[rd_ptr_q];
  assign push        = req_valid_i && !req_stall_o;

  always_comb begin
    job_new.hdr       = req_i;
    job_new.same_addr = (req_i.src_addr == req_i.dst_addr);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(lbf_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (job_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(lbf_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !job_pop_i) begin
      fill_d = fill_q + CntW'(1);
    end else if (!push && job_pop_i) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= job_new;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lbf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbf_back: address table engine
// Scans the address table one entry per cycle for the destination and the
// source, decides the action, learns an unknown source and holds the result.
// ----------------------------------------------------------------------------
module lbf_back #(
  parameter int unsigned TABLE_DEPTH = lbf_pkg::DefaultTableDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire lbf_pkg::job_t job_i,
  output logic               job_pop_o,
  output logic               res_valid_o,
  input  wire logic          res_stall_i,
  output lbf_pkg::res_t      res_o,
  output lbf_pkg::back_stat_t stat_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // Entries fill in index order, so the fill count alone tells which are valid.
  logic [lbf_pkg::AddrWidth-1:0] addr_mem [TABLE_DEPTH];
  logic                          port_mem [TABLE_DEPTH];

  lbf_pkg::back_state_e          state_q, state_d;
  lbf_pkg::job_t                 job_q;
  logic [CntW-1:0]               scan_q;
  logic [CntW-1:0]               count_q;
  logic                          pend_q;
  logic                          dst_hit_q, dst_port_q, src_hit_q;
  logic [lbf_pkg::AddrWidth-1:0] rd_addr_q;
  logic                          rd_port_q;
  logic                          res_valid_q;
  lbf_pkg::res_t                 res_q, res_d;

  logic out_free, rd_en, finish_go, table_full, src_known, learn_wr;
  logic dst_match, src_match;
  logic [CntW-1:0] scan_inc;

  assign out_free   = !res_valid_q || !res_stall_i;
  assign scan_inc   = scan_q + CntW'(1);
  assign table_full = (count_q == CntW'(TABLE_DEPTH));
  assign dst_match  = pend_q && (rd_addr_q == job_q.hdr.dst_addr);
  assign src_match  = pend_q && (rd_addr_q == job_q.hdr.src_addr);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lbf_pkg::StIdle: begin
        if (job_valid_i) begin
          state_d = (count_q == '0) ? lbf_pkg::StFinish : lbf_pkg::StScan;
        end
      end
      lbf_pkg::StScan: begin
        if (scan_inc == count_q) begin
          state_d = lbf_pkg::StDrain;
        end
      end
      lbf_pkg::StDrain: begin
        state_d = lbf_pkg::StFinish;
      end
      lbf_pkg::StFinish: begin
        if (out_free) begin
          state_d = lbf_pkg::StIdle;
        end
      end
      default: begin
        state_d = lbf_pkg::StIdle;
      end
    endcase
  end

  // State outputs and the decision.
  always_comb begin
    job_pop_o = 1'b0;
    rd_en     = 1'b0;
    finish_go = 1'b0;
    case (state_q)
      lbf_pkg::StIdle:   job_pop_o = job_valid_i;
      lbf_pkg::StScan:   rd_en     = 1'b1;
      lbf_pkg::StFinish: finish_go = out_free;
      default: begin
      end
    endcase

    src_known = src_hit_q || (job_q.same_addr && dst_hit_q);
    learn_wr  = finish_go && !src_known && !table_full;

    res_d.out_port = 1'b0;
    if (!dst_hit_q) begin
      res_d.action = lbf_pkg::ActFlood;
    end else if (dst_port_q == job_q.hdr.ingress_port) begin
      res_d.action = lbf_pkg::ActFilter;
    end else begin
      res_d.action   = lbf_pkg::ActForward;
      res_d.out_port = dst_port_q;
    end
    res_d.learned       = !src_known && !table_full;
    res_d.learn_dropped = !src_known && table_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbf_pkg::StIdle;
      count_q     <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_en;
      if (learn_wr) begin
        count_q <= count_q + CntW'(1);
      end
      if (finish_go) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q     <= job_i;
      scan_q    <= '0;
      dst_hit_q <= 1'b0;
      src_hit_q <= 1'b0;
    end else begin
      if (rd_en) begin
        scan_q <= scan_inc;
      end
      if (dst_match && !dst_hit_q) begin
        dst_hit_q  <= 1'b1;
        dst_port_q <= rd_port_q;
      end
      if (src_match) begin
        src_hit_q <= 1'b1;
      end
    end
    if (finish_go) begin
      res_q <= res_d;
    end
  end

  // Table memory: one write port for learning, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (learn_wr) begin
      addr_mem[count_q[IdxW-1:0]] <= job_q.hdr.src_addr;
      port_mem[count_q[IdxW-1:0]] <= job_q.hdr.ingress_port;
    end
    if (rd_en) begin
      rd_addr_q <= addr_mem[scan_q[IdxW-1:0]];
      rd_port_q <= port_mem[scan_q[IdxW-1:0]];
    end
  end

  assign res_valid_o       = res_valid_q;
  assign res_o             = res_q;
  assign stat_o.table_full = table_full;
  assign stat_o.learn_wr   = learn_wr;

endmodule
`default_nettype wire
